// ===== rtl/clmp_pkg.sv =====
// ----------------------------------------------------------------------------
// clmp_pkg: shared types and constants of the link monitor and poller
// Payload structs, job descriptor, poll opcodes and field widths.
// ----------------------------------------------------------------------------
package clmp_pkg;

   localparam int FRAME_BYTES         = 5;
   localparam int BCD_DIGITS_DEFAULT  = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int FREQ_W  = 28;
   localparam int COUNT_W = 3;
   localparam int BEAT_W  = 3;

   localparam logic [FREQ_W-1:0] FREQ_MAX = 28'd166666665;

   localparam logic [7:0] OPCODE_RESET = 8'h03;
   localparam logic [7:0] PAD_BYTE     = 8'hFF;
   localparam logic [7:0] OPC_FREQ     = 8'h03;
   localparam logic [7:0] OPC_STATUS   = 8'hF7;
   localparam logic [7:0] OPC_RXSTATUS = 8'hE7;

   // input item kinds
   localparam logic [1:0] MODE_HOST  = 2'd0;
   localparam logic [1:0] MODE_RADIO = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic PORT_RADIO = 1'b0;
   localparam logic PORT_HOST  = 1'b1;

   // poll sequence: beats per poll and position of the opcode byte
   localparam int FREQ_POLL_BEATS  = 8;
   localparam int SHORT_POLL_BEATS = 5;
   localparam int OPCODE_BEAT      = 4;

   typedef enum logic [1:0] {
      EXP_NONE     = 2'd0,
      EXP_FREQ     = 2'd1,
      EXP_STATUS   = 2'd2,
      EXP_RXSTATUS = 2'd3
   } expect_type;

   typedef enum logic [1:0] {
      STEP_FREQ     = 2'd0,
      STEP_STATUS   = 2'd1,
      STEP_RXSTATUS = 2'd2,
      STEP_IDLE     = 2'd3
   } poll_step_type;

   typedef enum logic {
      JOB_ECHO = 1'b0,
      JOB_POLL = 1'b1
   } job_kind_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic              dest_port;
      logic [7:0]        out_byte;
      logic              last;
      logic [FREQ_W-1:0] frequency;
      logic [7:0]        op_mode;
      logic              poll_active;
      logic              standalone_seen;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] frequency;
      logic [7:0]        op_mode;
      logic              poll_active;
      logic              standalone_seen;
   } status_type;

   typedef struct packed {
      job_kind_type  kind;
      logic          port;
      logic [7:0]    data;
      poll_step_type step;
      status_type    status;
   } job_type;

   function automatic logic [7:0] poll_opcode(input poll_step_type step);
      logic [7:0] opc;
      case (step)
         STEP_FREQ:     opc = OPC_FREQ;
         STEP_STATUS:   opc = OPC_STATUS;
         STEP_RXSTATUS: opc = OPC_RXSTATUS;
         default:       opc = PAD_BYTE;
      endcase
      return opc;
   endfunction

endpackage

// ===== rtl/clmp_front.sv =====
// ----------------------------------------------------------------------------
// clmp_front: item classifier and link state
// Tracks frames, expected reply and poll step; posts jobs to the queue.
// ----------------------------------------------------------------------------
module clmp_front #(
   parameter int BCD_DIGITS = clmp_pkg::BCD_DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   input  logic              accept,
   input  clmp_pkg::req_type req_data,
   output logic              push,
   output clmp_pkg::job_type push_job
);
   import clmp_pkg::*;

   localparam int FULL_BYTES = BCD_DIGITS / 2;
   localparam bit HAS_HALF   = (BCD_DIGITS % 2) == 1;

   logic [7:0]         opcode_ff;
   logic [COUNT_W-1:0] host_cnt_ff, host_cnt_in;
   logic [COUNT_W-1:0] radio_cnt_ff, radio_cnt_in;
   expect_type         expect_ff, expect_in;
   poll_step_type      step_ff, step_in;
   logic               host_seen_ff, host_seen_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [7:0]         rmode_ff, rmode_in;
   logic               polling_ff, polling_in;
   logic               standalone_ff, standalone_in;
   logic [FREQ_W-1:0]  acc_ff, acc_in;
   logic [FREQ_W-1:0]  acc_base;
   logic [FREQ_W-1:0]  hi_digit, lo_digit;

   // running BCD accumulation, two digits per radio byte (one for a trailing half byte)
   always_comb begin
      acc_base = (radio_cnt_ff == '0) ? '0 : acc_ff;
      hi_digit = FREQ_W'(req_data.data_byte[7:4]);
      lo_digit = FREQ_W'(req_data.data_byte[3:0]);
      if (radio_cnt_ff < COUNT_W'(FULL_BYTES)) begin
         acc_in = acc_base * FREQ_W'(100) + hi_digit * FREQ_W'(10) + lo_digit;
      end else if (HAS_HALF && radio_cnt_ff == COUNT_W'(FULL_BYTES)) begin
         acc_in = acc_base * FREQ_W'(10) + hi_digit;
      end else begin
         acc_in = acc_base;
      end
   end

   always_comb begin
      host_cnt_in   = host_cnt_ff;
      radio_cnt_in  = radio_cnt_ff;
      expect_in     = expect_ff;
      step_in       = step_ff;
      host_seen_in  = host_seen_ff;
      freq_in       = freq_ff;
      rmode_in      = rmode_ff;
      polling_in    = polling_ff;
      standalone_in = standalone_ff;
      push          = 1'b0;
      push_job.kind = JOB_ECHO;
      push_job.port = PORT_RADIO;
      push_job.data = req_data.data_byte;
      push_job.step = step_ff;
      if (accept) begin
         case (req_data.mode)
            MODE_HOST: begin
               if (host_cnt_ff == COUNT_W'(FRAME_BYTES - 1)) begin
                  host_cnt_in  = '0;
                  expect_in    = (req_data.data_byte == opcode_ff) ? EXP_FREQ : EXP_NONE;
                  radio_cnt_in = '0;
               end else begin
                  host_cnt_in = host_cnt_ff + COUNT_W'(1);
               end
               host_seen_in = 1'b1;
               push         = 1'b1;
            end
            MODE_RADIO: begin
               if (radio_cnt_ff == COUNT_W'(FRAME_BYTES - 1)) begin
                  radio_cnt_in = '0;
                  if (expect_ff == EXP_FREQ) begin
                     freq_in  = acc_in;
                     rmode_in = req_data.data_byte;
                  end
               end else begin
                  radio_cnt_in = radio_cnt_ff + COUNT_W'(1);
               end
               push_job.port = PORT_HOST;
               push          = 1'b1;
            end
            MODE_TICK: begin
               if (!host_seen_ff) begin
                  radio_cnt_in = '0;
                  case (step_ff)
                     STEP_FREQ:     expect_in = EXP_FREQ;
                     STEP_STATUS:   expect_in = EXP_STATUS;
                     STEP_RXSTATUS: begin
                        expect_in     = EXP_RXSTATUS;
                        standalone_in = 1'b1;
                     end
                     default: ;
                  endcase
                  if (step_ff == STEP_IDLE) begin
                     step_in    = STEP_FREQ;
                     polling_in = 1'b0;
                  end else begin
                     polling_in    = 1'b1;
                     step_in       = poll_step_type'(step_ff + 2'd1);
                     push_job.kind = JOB_POLL;
                     push          = 1'b1;
                  end
               end
               host_seen_in = 1'b0;
            end
            default: ;
         endcase
      end
      push_job.status.frequency       = freq_in;
      push_job.status.op_mode         = rmode_in;
      push_job.status.poll_active     = polling_in;
      push_job.status.standalone_seen = standalone_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff     <= OPCODE_RESET;
         host_cnt_ff   <= '0;
         radio_cnt_ff  <= '0;
         expect_ff     <= EXP_NONE;
         step_ff       <= STEP_FREQ;
         host_seen_ff  <= 1'b0;
         freq_ff       <= '0;
         rmode_ff      <= '0;
         polling_ff    <= 1'b0;
         standalone_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            opcode_ff <= csr_wdata;
         end
         host_cnt_ff   <= host_cnt_in;
         radio_cnt_ff  <= radio_cnt_in;
         expect_ff     <= expect_in;
         step_ff       <= step_in;
         host_seen_ff  <= host_seen_in;
         freq_ff       <= freq_in;
         rmode_ff      <= rmode_in;
         polling_ff    <= polling_in;
         standalone_ff <= standalone_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.mode == MODE_RADIO) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== rtl/clmp_fifo.sv =====
// ----------------------------------------------------------------------------
// clmp_fifo: job queue
// Small register queue between classifier and byte sequencer.
// ----------------------------------------------------------------------------
module clmp_fifo #(
   parameter int QUEUE_DEPTH = clmp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clmp_pkg::job_type push_job,
   input  logic              pop,
   output clmp_pkg::job_type pop_job,
   output logic              full,
   output logic              empty
);
   import clmp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/clmp_back.sv =====
// ----------------------------------------------------------------------------
// clmp_back: byte sequencer
// Expands one job into its result words, one word per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module clmp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  clmp_pkg::job_type pop_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clmp_pkg::rsp_type rsp_data
);
   import clmp_pkg::*;

   job_type           cur_ff;
   logic              cur_valid_ff, cur_valid_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [BEAT_W-1:0] final_beat;
   logic              is_last;
   logic              take;

   always_comb begin
      if (cur_ff.kind == JOB_ECHO) begin
         final_beat = '0;
      end else if (cur_ff.step == STEP_FREQ) begin
         final_beat = BEAT_W'(FREQ_POLL_BEATS - 1);
      end else begin
         final_beat = BEAT_W'(SHORT_POLL_BEATS - 1);
      end
   end

   assign is_last   = (beat_ff == final_beat);
   assign take      = rsp_valid && rsp_ready;
   assign rsp_valid = cur_valid_ff;
   // load the next job when idle or as the final word leaves
   assign pop       = !empty && (!cur_valid_ff || (take && is_last));

   always_comb begin
      rsp_data.dest_port = cur_ff.port;
      rsp_data.last      = is_last;
      if (cur_ff.kind == JOB_ECHO) begin
         rsp_data.out_byte = cur_ff.data;
      end else if (beat_ff == BEAT_W'(OPCODE_BEAT)) begin
         rsp_data.out_byte = poll_opcode(cur_ff.step);
      end else begin
         rsp_data.out_byte = PAD_BYTE;
      end
      rsp_data.frequency       = cur_ff.status.frequency;
      rsp_data.op_mode         = cur_ff.status.op_mode;
      rsp_data.poll_active     = cur_ff.status.poll_active;
      rsp_data.standalone_seen = cur_ff.status.standalone_seen;
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      beat_in      = beat_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         beat_in      = '0;
      end else if (take) begin
         if (is_last) begin
            cur_valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + BEAT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         beat_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_job;
      end
   end

endmodule

// ===== rtl/cat_link_monitor_poller_unit.sv =====
// A word accepted into an empty block is written into the job queue, then loaded by the
//   byte sequencer, before its first result word shows.
// Throughput: one byte word per cycle while the job queue has room; a poll tick yields 8
//   (frequency) or 5 result words, one per cycle while rsp_ready is high, from the byte sequencer.
// The job queue lets new words enter while earlier poll bytes still drain.
// Reset (synchronous, active high) clears counters, flags and queue, query opcode to 0x03.
// ----------------------------------------------------------------------------
// cat_link_monitor_poller_unit: host/radio five-byte link bridge and poller
// Forwards and echoes link bytes, decodes frequency replies, issues polls.
// ----------------------------------------------------------------------------
module cat_link_monitor_poller_unit #(
   parameter int BCD_DIGITS  = clmp_pkg::BCD_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH = clmp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  clmp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clmp_pkg::rsp_type rsp_data
);
   import clmp_pkg::*;

   logic    accept;
   logic    push, pop;
   logic    fifo_full, fifo_empty;
   job_type push_job, pop_job;

   // Stall the input only when the job queue has no room; every word is
   // classified in its accept cycle, so state never waits on the back end.
   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;

   // Front: update frame counters, reply expectation and poll step,
   // and post a job carrying the status snapshot for its result words.
   clmp_front #(
      .BCD_DIGITS (BCD_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .push      (push),
      .push_job  (push_job)
   );

   // Queue: decouple classification from byte output.
   clmp_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   // Back: expand each job into echo or poll bytes, holding under stall.
   clmp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (fifo_empty),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // a radio echo is always a single-word result
   a_host_echo_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dest_port == PORT_HOST |-> rsp_data.last)
      else $error("host echo word not marked last");

   // final word leaving with nothing queued must idle the output
   a_drain_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last && fifo_empty |=> !rsp_valid)
      else $error("output still valid after draining last job");

   // decoded frequency stays within the eight-digit place-value bound
   a_freq_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.frequency <= FREQ_MAX)
      else $error("frequency out of range");
`endif

endmodule
